### src/keyboard_text_console_assert.svh
// assertion macros used by the console datapath
`ifndef KEYBOARD_TEXT_CONSOLE_ASSERT_SVH
`define KEYBOARD_TEXT_CONSOLE_ASSERT_SVH

`ifndef SYNTH
`define KTC_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("console assertion failed");
`define KTC_NEVER(lbl, cond) `KTC_ASSERT(lbl, !(cond))
`else
`define KTC_ASSERT(lbl, prop)
`define KTC_NEVER(lbl, cond)
`endif

`endif

### src/ktc_pkg.sv
package ktc_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = 11;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int TAB_W      = 3;
  localparam int TAB_STOP   = 4;

  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;

  localparam logic [7:0] CH_NONE  = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] ATTR_RESET = 8'h0E;
  localparam logic       REG_TEXT_ATTR = 1'b0;

  localparam logic [7:0] MAP_PLAIN [64] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] MAP_UPPER [64] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLR_WR,
    OP_SHIFT_SET,
    OP_SHIFT_CLR,
    OP_MEM_RD,
    OP_RD_DONE,
    OP_PUT,
    OP_PUT_SPACE,
    OP_BS,
    OP_NL,
    OP_TAB_INIT,
    OP_SCR_INIT,
    OP_SCR_RD,
    OP_SCR_WR,
    OP_BLANK_WR,
    OP_SCR_END,
    OP_RESULT
  } ktc_op_e;

  typedef struct packed {
    ktc_op_e op;
  } ktc_cmd_t;

  typedef struct packed {
    logic       idx_last;
    logic       idx_move_last;
    logic       put_wrap;
    logic       nl_wrap;
    logic       tab_zero;
    logic       out_free;
    logic       is_read;
    logic       addr_ok;
    logic [7:0] sc;
    logic [7:0] ch;
  } ktc_stat_t;

endpackage

### src/ktc_in_if.sv
interface ktc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [7:0]                  scancode;
  logic [ktc_pkg::ADDR_W-1:0]  cell_address;

  modport source (output valid, output cmd, output scancode, output cell_address,
                  input ready);
  modport sink (input valid, input cmd, input scancode, input cell_address,
                output ready);
endinterface

### src/ktc_out_if.sv
interface ktc_out_if;
  logic                        valid;
  logic                        ready;
  logic [15:0]                 cell_data;
  logic [ktc_pkg::ADDR_W-1:0]  cursor_position;
  logic                        shift_held;

  modport source (output valid, output cell_data, output cursor_position,
                  output shift_held, input ready);
  modport sink (input valid, input cell_data, input cursor_position,
                input shift_held, output ready);
endinterface

### src/keyboard_text_console.sv
// Scancode text console: each request is either a set 1 keyboard scancode or a
// read of one screen cell, and yields one result with the cell data, the cursor
// and the shift state. After reset the screen RAM is swept to blanks before the
// first request is taken. No new request is taken until the last one has loaded
// its result into the output register. A tab writes up to four cells; a key that
// runs past the last cell, or a newline on the last row, scrolls the screen: each
// moved cell is read and written back one row up, then the last row is blanked.
module keyboard_text_console (
  input  logic        clk_i,
  input  logic        rst_ni,
  ktc_in_if.sink      in_i,
  ktc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ktc_pkg::*;

  logic       [7:0] attr_q;
  ktc_cmd_t         cmd;
  ktc_stat_t        stat;
  logic             in_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'h0, attr_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TEXT_ATTR) begin
      attr_q <= pwdata[7:0];
    end
  end

  assign in_i.ready = in_ready;

  ktc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ktc_dpath u_dpath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .attr_i                (attr_q),
    .in_cmd_i              (in_i.cmd),
    .in_scancode_i         (in_i.scancode),
    .in_cell_address_i     (in_i.cell_address),
    .out_ready_i           (out_o.ready),
    .out_valid_o           (out_o.valid),
    .out_cell_data_o       (out_o.cell_data),
    .out_cursor_position_o (out_o.cursor_position),
    .out_shift_held_o      (out_o.shift_held)
  );

endmodule

### src/ktc_ctrl.sv
module ktc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ktc_pkg::ktc_stat_t stat_i,
  output ktc_pkg::ktc_cmd_t  cmd_o
);
  import ktc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_TAB,
    S_SCR_INIT,
    S_SCR_RD,
    S_SCR_WR,
    S_SCR_BLANK,
    S_SCR_END,
    S_RESULT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLR_WR;
        if (stat_i.idx_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESULT;
        if (stat_i.is_read) begin
          if (stat_i.addr_ok) begin
            cmd_o.op = OP_MEM_RD;
            state_d  = S_RD_WAIT;
          end
        end else if (stat_i.sc == SC_LSHIFT || stat_i.sc == SC_RSHIFT) begin
          cmd_o.op = OP_SHIFT_SET;
        end else if (stat_i.sc == SC_LSHIFT_REL || stat_i.sc == SC_RSHIFT_REL) begin
          cmd_o.op = OP_SHIFT_CLR;
        end else begin
          unique case (stat_i.ch)
            CH_NONE: cmd_o.op = OP_NONE;
            CH_BS:   cmd_o.op = OP_BS;
            CH_NL: begin
              cmd_o.op = OP_NL;
              if (stat_i.nl_wrap) state_d = S_SCR_INIT;
            end
            CH_TAB: begin
              cmd_o.op = OP_TAB_INIT;
              state_d  = S_TAB;
            end
            default: begin
              cmd_o.op = OP_PUT;
              if (stat_i.put_wrap) state_d = S_SCR_INIT;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd_o.op = OP_RD_DONE;
        state_d  = S_RESULT;
      end
      S_TAB: begin
        if (stat_i.tab_zero) begin
          state_d = S_RESULT;
        end else begin
          cmd_o.op = OP_PUT_SPACE;
          if (stat_i.put_wrap) state_d = S_SCR_INIT;
        end
      end
      S_SCR_INIT: begin
        cmd_o.op = OP_SCR_INIT;
        state_d  = S_SCR_RD;
      end
      S_SCR_RD: begin
        cmd_o.op = OP_SCR_RD;
        state_d  = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd_o.op = OP_SCR_WR;
        state_d  = stat_i.idx_move_last ? S_SCR_BLANK : S_SCR_RD;
      end
      S_SCR_BLANK: begin
        cmd_o.op = OP_BLANK_WR;
        if (stat_i.idx_last) state_d = S_SCR_END;
      end
      S_SCR_END: begin
        cmd_o.op = OP_SCR_END;
        state_d  = S_TAB;
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/ktc_dpath.sv
`include "keyboard_text_console_assert.svh"

module ktc_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ktc_pkg::ktc_cmd_t          cmd_i,
  output ktc_pkg::ktc_stat_t         stat_o,
  input  logic [7:0]                 attr_i,
  input  logic                       in_cmd_i,
  input  logic [7:0]                 in_scancode_i,
  input  logic [ktc_pkg::ADDR_W-1:0] in_cell_address_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [15:0]                out_cell_data_o,
  output logic [ktc_pkg::ADDR_W-1:0] out_cursor_position_o,
  output logic                       out_shift_held_o
);
  import ktc_pkg::*;

  logic [15:0]       mem_q [CELL_COUNT];
  logic [15:0]       rdata_q;
  logic [ADDR_W-1:0] idx_q;
  logic [ADDR_W-1:0] cursor_q;
  logic [COL_W-1:0]  col_q;
  logic [TAB_W-1:0]  tab_q;
  logic              shift_q;
  logic              out_valid_q;
  logic              cmd_q;
  logic [7:0]        sc_q;
  logic [ADDR_W-1:0] addr_q;
  logic [15:0]       res_data_q;
  logic [15:0]       out_data_q;
  logic [ADDR_W-1:0] out_cursor_q;
  logic              out_shift_q;

  logic [7:0]        ch;
  logic [15:0]       blank;
  logic [ADDR_W-1:0] row_start;
  logic              put_wrap;
  logic              nl_wrap;
  logic              bs_ok;
  logic              last_col;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  always_comb begin
    ch = CH_NONE;
    if (sc_q[7:6] == 2'b00) begin
      ch = shift_q ? MAP_UPPER[sc_q[5:0]] : MAP_PLAIN[sc_q[5:0]];
    end
  end

  assign blank     = {attr_i, CH_SPACE};
  assign row_start = cursor_q - ADDR_W'(col_q);
  assign put_wrap  = (cursor_q == ADDR_W'(CELL_COUNT - 1));
  assign nl_wrap   = (row_start == ADDR_W'(CELL_COUNT - COLUMNS));
  assign bs_ok     = (cursor_q > ADDR_W'(COLUMNS));
  assign last_col  = (col_q == COL_W'(COLUMNS - 1));

  assign stat_o.idx_last      = (idx_q == ADDR_W'(CELL_COUNT - 1));
  assign stat_o.idx_move_last = (idx_q == ADDR_W'(CELL_COUNT - COLUMNS - 1));
  assign stat_o.put_wrap      = put_wrap;
  assign stat_o.nl_wrap       = nl_wrap;
  assign stat_o.tab_zero      = (tab_q == '0);
  assign stat_o.out_free      = !out_valid_q || out_ready_i;
  assign stat_o.is_read       = cmd_q;
  assign stat_o.addr_ok       = (addr_q < ADDR_W'(CELL_COUNT));
  assign stat_o.sc            = sc_q;
  assign stat_o.ch            = ch;

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = blank;
    re    = 1'b0;
    raddr = ADDR_W'(idx_q + ADDR_W'(COLUMNS));
    case (cmd_i.op)
      OP_CLR_WR: begin
        we    = 1'b1;
        wdata = {ATTR_RESET, CH_SPACE};
      end
      OP_PUT: begin
        we    = 1'b1;
        waddr = cursor_q;
        wdata = {attr_i, ch};
      end
      OP_PUT_SPACE: begin
        we    = 1'b1;
        waddr = cursor_q;
      end
      OP_BS: begin
        we    = bs_ok;
        waddr = cursor_q - ADDR_W'(1);
      end
      OP_SCR_WR: begin
        we    = 1'b1;
        wdata = rdata_q;
      end
      OP_BLANK_WR: we = 1'b1;
      OP_SCR_RD:   re = 1'b1;
      OP_MEM_RD: begin
        re    = 1'b1;
        raddr = addr_q;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cursor_q    <= ADDR_W'(COLUMNS);
      col_q       <= '0;
      tab_q       <= '0;
      shift_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_RESULT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_LATCH:     tab_q <= '0;
        OP_CLR_WR:    idx_q <= idx_q + ADDR_W'(1);
        OP_SHIFT_SET: shift_q <= 1'b1;
        OP_SHIFT_CLR: shift_q <= 1'b0;
        OP_PUT, OP_PUT_SPACE: begin
          if (cmd_i.op == OP_PUT_SPACE) tab_q <= tab_q - TAB_W'(1);
          if (!put_wrap) begin
            cursor_q <= cursor_q + ADDR_W'(1);
            col_q    <= last_col ? '0 : col_q + COL_W'(1);
          end
        end
        OP_BS: begin
          if (bs_ok) begin
            cursor_q <= cursor_q - ADDR_W'(1);
            col_q    <= (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - COL_W'(1);
          end
        end
        OP_NL: begin
          if (!nl_wrap) begin
            cursor_q <= row_start + ADDR_W'(COLUMNS);
            col_q    <= '0;
          end
        end
        OP_TAB_INIT:  tab_q <= TAB_W'(TAB_STOP) - TAB_W'(col_q[1:0]);
        OP_SCR_INIT:  idx_q <= '0;
        OP_SCR_WR:    idx_q <= idx_q + ADDR_W'(1);
        OP_BLANK_WR:  idx_q <= idx_q + ADDR_W'(1);
        OP_SCR_END: begin
          cursor_q <= ADDR_W'(CELL_COUNT - COLUMNS);
          col_q    <= '0;
        end
        default:      idx_q <= idx_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      cmd_q      <= in_cmd_i;
      sc_q       <= in_scancode_i;
      addr_q     <= in_cell_address_i;
      res_data_q <= '0;
    end
    if (cmd_i.op == OP_RD_DONE) res_data_q <= rdata_q;
    if (cmd_i.op == OP_RESULT) begin
      out_data_q   <= res_data_q;
      out_cursor_q <= cursor_q;
      out_shift_q  <= shift_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_cell_data_o       = out_data_q;
  assign out_cursor_position_o = out_cursor_q;
  assign out_shift_held_o      = out_shift_q;

  `KTC_NEVER(cursor_range_a, cursor_q >= ADDR_W'(CELL_COUNT))
  `KTC_NEVER(col_range_a, col_q >= COL_W'(COLUMNS))
  `KTC_ASSERT(out_load_a, $rose(out_valid_q) |-> $past(cmd_i.op == OP_RESULT))

endmodule

### tb/keyboard_text_console_checker.sv
`timescale 1ns / 1ps

module keyboard_text_console_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ktc_in_if           in_m,
  ktc_out_if          out_m,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors_o,
  output int          pending_o
);
  import ktc_pkg::*;

  typedef struct {
    logic [15:0]       cell_data;
    logic [ADDR_W-1:0] cursor_position;
    logic              shift_held;
  } console_result_t;

  localparam int KEYMAP_LEN = 58;

  localparam logic [7:0] KEYS_LOWER [KEYMAP_LEN] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  localparam logic [7:0] KEYS_SHIFTED [KEYMAP_LEN] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  logic [15:0]     screen [CELL_COUNT];
  int              cursor;
  logic            shifted;
  logic [7:0]      attr;
  console_result_t predicted_results [$];
  int              errors;

  assign errors_o  = errors;
  assign pending_o = predicted_results.size();

  task automatic scroll_screen();
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = {attr, CH_SPACE};
    cursor = COLUMNS * (ROWS - 1);
  endtask

  task automatic put_char(logic [7:0] ch);
    if (cursor < CELL_COUNT) screen[cursor] = {attr, ch};
    cursor++;
    if (cursor >= CELL_COUNT) scroll_screen();
  endtask

  task automatic type_key(logic [7:0] sc);
    logic [7:0] ch;
    int         pad;
    if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
      shifted = 1'b1;
    end else if (sc == SC_LSHIFT_REL || sc == SC_RSHIFT_REL) begin
      shifted = 1'b0;
    end else if (!sc[7] && sc < KEYMAP_LEN) begin
      ch = shifted ? KEYS_SHIFTED[sc] : KEYS_LOWER[sc];
      if (ch == CH_BS) begin
        if (cursor > COLUMNS) begin
          cursor--;
          if (cursor < CELL_COUNT) screen[cursor] = {attr, CH_SPACE};
        end
      end else if (ch == CH_NL) begin
        cursor = (cursor / COLUMNS + 1) * COLUMNS;
        if (cursor >= CELL_COUNT) scroll_screen();
      end else if (ch == CH_TAB) begin
        pad = TAB_STOP - ((cursor % COLUMNS) % TAB_STOP);
        for (int i = 0; i < pad; i++) put_char(CH_SPACE);
      end else if (ch != CH_NONE) begin
        put_char(ch);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    console_result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < CELL_COUNT; i++) screen[i] = {ATTR_RESET, CH_SPACE};
      cursor  = COLUMNS;
      shifted = 1'b0;
      attr    = ATTR_RESET;
      errors  = 0;
      predicted_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0) attr = pwdata[7:0];
      if (in_m.valid && in_m.ready) begin
        exp_r.cell_data = 16'h0000;
        if (!in_m.cmd) type_key(in_m.scancode);
        else if (in_m.cell_address < CELL_COUNT) exp_r.cell_data = screen[in_m.cell_address];
        exp_r.cursor_position = cursor[ADDR_W-1:0];
        exp_r.shift_held      = shifted;
        predicted_results.push_back(exp_r);
      end
      if (out_m.valid && out_m.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          exp_r = predicted_results.pop_front();
          if (out_m.cell_data !== exp_r.cell_data) begin
            $error("cell_data expected %h actual %h", exp_r.cell_data, out_m.cell_data);
            errors++;
          end
          if (out_m.cursor_position !== exp_r.cursor_position) begin
            $error("cursor_position expected %0d actual %0d", exp_r.cursor_position,
                   out_m.cursor_position);
            errors++;
          end
          if (out_m.shift_held !== exp_r.shift_held) begin
            $error("shift_held expected %b actual %b", exp_r.shift_held, out_m.shift_held);
            errors++;
          end
        end
      end
    end
  end
endmodule

### tb/keyboard_text_console_tb.sv
`timescale 1ns / 1ps

module keyboard_text_console_tb;
  import ktc_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        no_idle;
  int          errors, pending, quiet_cycles;

  ktc_in_if  in_if ();
  ktc_out_if out_if ();

  keyboard_text_console uut (
    .clk_i, .rst_ni, .in_i(in_if), .out_o(out_if),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  keyboard_text_console_checker console_check (
    .clk_i, .rst_ni, .in_m(in_if), .out_m(out_if),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid = 1'b0; in_if.cmd = 1'b0; in_if.scancode = '0; in_if.cell_address = '0;
    out_if.ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    no_idle = 1'b0;
  end

  // result-side stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_request(logic cmd, logic [7:0] sc, logic [ADDR_W-1:0] addr);
    in_if.valid        <= 1'b1;
    in_if.cmd          <= cmd;
    in_if.scancode     <= sc;
    in_if.cell_address <= addr;
    do @(posedge clk_i); while (!in_if.ready);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic write_attribute(logic [7:0] value);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'd0;
    pwdata <= {24'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic random_requests(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20)      send_request(1'b0, 8'h1C, ADDR_W'($urandom));
      else if (pick < 30) send_request(1'b1, 8'($urandom),
                                       ADDR_W'($urandom_range(0, CELL_COUNT - 1)));
      else if (pick < 33) send_request(1'b1, 8'($urandom), ADDR_W'($urandom_range(0, 2047)));
      else if (pick < 40) send_request(1'b0, 8'($urandom), ADDR_W'($urandom));
      else if (pick < 45) send_request(1'b0, 8'h0E, ADDR_W'($urandom));
      else if (pick < 50) send_request(1'b0, 8'h0F, ADDR_W'($urandom));
      else if (pick < 58) begin
        case ($urandom_range(0, 3))
          0: send_request(1'b0, SC_LSHIFT, ADDR_W'($urandom));
          1: send_request(1'b0, SC_RSHIFT, ADDR_W'($urandom));
          2: send_request(1'b0, SC_LSHIFT_REL, ADDR_W'($urandom));
          default: send_request(1'b0, SC_RSHIFT_REL, ADDR_W'($urandom));
        endcase
      end
      else if (pick < 62) send_request(1'b0, 8'h80 | 8'($urandom_range(0, 127)),
                                       ADDR_W'($urandom));
      else send_request(1'b0, 8'($urandom_range(0, 57)), ADDR_W'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    send_request(1'b1, 8'h00, 11'd0);
    send_request(1'b1, 8'hFF, 11'd1999);
    send_request(1'b1, 8'h00, 11'd2047);
    send_request(1'b0, 8'h0E, 11'd0);
    send_request(1'b0, 8'h10, 11'd0);
    send_request(1'b0, 8'h0E, 11'd0);
    send_request(1'b0, 8'h0E, 11'd0);
    send_request(1'b0, 8'h0F, 11'd0);
    send_request(1'b0, 8'h39, 11'd0);
    send_request(1'b0, 8'h0F, 11'd0);
    send_request(1'b0, 8'h1C, 11'd0);
    send_request(1'b0, SC_LSHIFT, 11'd0);
    send_request(1'b0, 8'h02, 11'd0);
    send_request(1'b0, SC_LSHIFT_REL, 11'd0);
    send_request(1'b0, SC_RSHIFT, 11'd0);
    send_request(1'b0, 8'h35, 11'd0);
    send_request(1'b0, SC_RSHIFT_REL, 11'd0);
    send_request(1'b0, 8'h9E, 11'd0);
    send_request(1'b0, 8'h00, 11'd0);
    send_request(1'b0, 8'h1D, 11'd0);
    send_request(1'b0, 8'h3A, 11'd0);
    send_request(1'b0, 8'hFF, 11'd0);
    send_request(1'b1, 8'h00, 11'd80);
    send_request(1'b1, 8'h00, 11'd1024);

    write_attribute(8'hFF);
    random_requests(40);
    write_attribute(8'h00);
    random_requests(40);
    write_attribute(8'($urandom));
    no_idle <= 1'b1;
    random_requests(36);
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
